### hdl/dmlc_pkg.sv
// Package for the direct-mapped lookup cache: sizes, opcodes, request and
// result types and the command record passed from the front to the back end.
// No dependencies.
package dmlc_pkg;

	localparam int INDEX_BITS = 15;
	localparam int DEPTH      = 1 << INDEX_BITS;
	localparam int ADDR_W     = 64;
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 31;

	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [COUNT_W-1:0]    count_t;

	localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_SEARCH = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAN  = 2'd2,
		OP_INIT   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [ADDR_W-1:0]         lookup_address;
		logic signed [VALUE_W-1:0] line_in;
		logic signed [VALUE_W-1:0] function_in;
	} request_t;

	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] line_out;
		logic signed [VALUE_W-1:0] function_out;
		count_t                    hit_count;
		count_t                    miss_count;
		count_t                    replace_count;
	} result_t;

	typedef enum logic [1:0] {
		KIND_SEARCH,
		KIND_INSERT,
		KIND_SWEEP
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               zero_counts;
		logic [ADDR_W-1:0]  address;
		logic [VALUE_W-1:0] line_val;
		logic [VALUE_W-1:0] func_val;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	typedef struct packed {
		logic [VALUE_W-1:0] line_val;
		logic [VALUE_W-1:0] func_val;
	} data_entry_t;

	function automatic count_t sat_inc(input count_t c);
		return (c == COUNT_MAX) ? COUNT_MAX : c + count_t'(1);
	endfunction

endpackage

### hdl/direct_mapped_lookup_cache.sv
// Direct-mapped lookup cache, top level: the back end reads the tag and data memories for
// a search or insert, then evaluates it, and done is registered from that evaluate step.
// The back end takes no new request until idle again; the front-end queue holds it.
// A clean or initialize walks every entry; done is registered from the last entry of the walk.
// After reset the memories are cleared with busy high.
// Results are strobed by done for one cycle; the receiver cannot stall them.
module direct_mapped_lookup_cache
	import dmlc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	// The front end classifies each request and queues it. It holds up to
	// two requests, so a new request can be taken while the back end is
	// still working on an earlier one.
	head_t     head;
	back_ctl_t back_ctl;

	dmlc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.request  (request),
		.back_ctl (back_ctl),
		.busy     (busy),
		.head     (head)
	);

	// The back end owns the tag store, the line and function store and the
	// counters. A search or insert reads the entry at the low address bits,
	// compares the full stored address and writes on an insert miss. Clean
	// and initialize sweep the tags to zero, one entry per cycle. Zero is
	// the empty marker, so a search for address zero hits a cleared entry.
	dmlc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.back_ctl (back_ctl),
		.done     (done),
		.result   (result)
	);

endmodule

### hdl/dmlc_front.sv
// Front end of the lookup cache: takes requests, classifies them and holds
// them in a two-entry queue for the back end. Depends on dmlc_pkg.
module dmlc_front
	import dmlc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  request_t  request,
	input  back_ctl_t back_ctl,
	output logic      busy,
	output head_t     head
);

	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       entries_q [2];
	cmd_t       cmd_new;
	logic       push;

	// Busy while the queue is full or the back end is clearing after reset.
	assign busy = (count_q == 2'd2) || back_ctl.clearing;
	assign push = start && !busy;

	always_comb begin
		cmd_new.zero_counts = 1'b0;
		cmd_new.address     = request.lookup_address;
		cmd_new.line_val    = request.line_in;
		cmd_new.func_val    = request.function_in;
		unique case (request.op)
			OP_SEARCH: cmd_new.kind = KIND_SEARCH;
			OP_INSERT: cmd_new.kind = KIND_INSERT;
			OP_CLEAN:  cmd_new.kind = KIND_SWEEP;
			OP_INIT: begin
				cmd_new.kind        = KIND_SWEEP;
				cmd_new.zero_counts = 1'b1;
			end
		endcase
	end

	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (back_ctl.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			priority if (push && !back_ctl.pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && back_ctl.pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cmd_new;
		end
	end

	property p_no_pop_empty;
		@(posedge clk) disable iff (!arst_n) back_ctl.pop |-> count_q != 2'd0;
	endproperty
	a_no_pop_empty: assert property (p_no_pop_empty)
		else $error("queue popped while empty");

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) count_q == 2'd2 |=> count_q != 2'd3;
	endproperty
	a_no_overflow: assert property (p_no_overflow)
		else $error("queue count overflowed");

	property p_no_push_clearing;
		@(posedge clk) disable iff (!arst_n)
			back_ctl.clearing && !back_ctl.pop |=> count_q == $past(count_q);
	endproperty
	a_no_push_clearing: assert property (p_no_push_clearing)
		else $error("request taken during clearing pass");

endmodule

### hdl/dmlc_back.sv
// Back end of the lookup cache: tag and data memories, statistics counters
// and the sequencer for lookups, inserts and sweeps. Depends on dmlc_pkg.
module dmlc_back
	import dmlc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  head_t     head,
	output back_ctl_t back_ctl,
	output logic      done,
	output result_t   result
);

	typedef enum logic [1:0] {
		ST_CLEAR_ALL,
		ST_IDLE,
		ST_EVAL,
		ST_SWEEP
	} state_t;

	state_t      state_q;
	index_t      sweep_idx_q;
	count_t      hit_cnt_q;
	count_t      miss_cnt_q;
	count_t      repl_cnt_q;
	logic        done_q;
	cmd_t        cmd_q;
	result_t     result_q;

	logic [ADDR_W-1:0] tag_mem [DEPTH];
	data_entry_t       data_mem [DEPTH];
	logic [ADDR_W-1:0] tag_rd_q;
	data_entry_t       data_rd_q;

	index_t            rd_idx;
	index_t            wr_idx;
	logic              tag_we;
	logic              data_we;
	logic [ADDR_W-1:0] tag_wd;
	data_entry_t       data_wd;

	logic    pop;
	logic    match;
	logic    sweep_last;
	logic    rsp_load;
	count_t  hit_nx;
	count_t  miss_nx;
	count_t  repl_nx;
	result_t rsp_nx;

	assign pop        = (state_q == ST_IDLE) && head.valid;
	assign rd_idx     = head.cmd.address[INDEX_BITS-1:0];
	assign match      = (tag_rd_q == cmd_q.address);
	assign sweep_last = (sweep_idx_q == index_t'(DEPTH - 1));

	assign back_ctl.pop      = pop;
	assign back_ctl.clearing = (state_q == ST_CLEAR_ALL);

	always_comb begin
		tag_we   = 1'b0;
		data_we  = 1'b0;
		wr_idx   = sweep_idx_q;
		tag_wd   = '0;
		data_wd  = '0;
		hit_nx   = hit_cnt_q;
		miss_nx  = miss_cnt_q;
		repl_nx  = repl_cnt_q;
		rsp_load = 1'b0;
		unique case (state_q)
			ST_CLEAR_ALL: begin
				tag_we  = 1'b1;
				data_we = 1'b1;
			end
			ST_IDLE: begin
			end
			ST_EVAL: begin
				rsp_load = 1'b1;
				wr_idx   = cmd_q.address[INDEX_BITS-1:0];
				if (cmd_q.kind == KIND_SEARCH) begin
					if (match) begin
						hit_nx = sat_inc(hit_cnt_q);
					end else begin
						miss_nx = sat_inc(miss_cnt_q);
					end
				end else if (!match) begin
					tag_we           = 1'b1;
					data_we          = 1'b1;
					tag_wd           = cmd_q.address;
					data_wd.line_val = cmd_q.line_val;
					data_wd.func_val = cmd_q.func_val;
					repl_nx          = sat_inc(repl_cnt_q);
				end
			end
			ST_SWEEP: begin
				tag_we   = 1'b1;
				rsp_load = sweep_last;
				if (sweep_last && cmd_q.zero_counts) begin
					hit_nx  = '0;
					miss_nx = '0;
					repl_nx = '0;
				end
			end
		endcase
	end

	always_comb begin
		rsp_nx.hit           = (state_q == ST_EVAL) && (cmd_q.kind == KIND_SEARCH) && match;
		rsp_nx.line_out      = rsp_nx.hit ? data_rd_q.line_val : '0;
		rsp_nx.function_out  = rsp_nx.hit ? data_rd_q.func_val : '0;
		rsp_nx.hit_count     = hit_nx;
		rsp_nx.miss_count    = miss_nx;
		rsp_nx.replace_count = repl_nx;
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[wr_idx] <= tag_wd;
		end
		tag_rd_q <= tag_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[wr_idx] <= data_wd;
		end
		data_rd_q <= data_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR_ALL;
			sweep_idx_q <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			repl_cnt_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			hit_cnt_q  <= hit_nx;
			miss_cnt_q <= miss_nx;
			repl_cnt_q <= repl_nx;
			done_q     <= rsp_load;
			unique case (state_q)
				ST_CLEAR_ALL: begin
					sweep_idx_q <= sweep_idx_q + index_t'(1);
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					sweep_idx_q <= '0;
					if (pop) begin
						state_q <= (head.cmd.kind == KIND_SWEEP) ? ST_SWEEP : ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					sweep_idx_q <= sweep_idx_q + index_t'(1);
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
		end
		if (rsp_load) begin
			result_q <= rsp_nx;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	property p_done_source;
		@(posedge clk) disable iff (!arst_n)
			done |-> ($past(state_q) == ST_EVAL) || ($past(state_q) == ST_SWEEP);
	endproperty
	a_done_source: assert property (p_done_source)
		else $error("result strobe without a finished request");

	property p_hit_only_search;
		@(posedge clk) disable iff (!arst_n)
			done && result.hit |-> cmd_q.kind == KIND_SEARCH;
	endproperty
	a_hit_only_search: assert property (p_hit_only_search)
		else $error("hit reported for a request that is not a search");

	property p_done_single;
		@(posedge clk) disable iff (!arst_n) done |=> !done;
	endproperty
	a_done_single: assert property (p_done_single)
		else $error("result strobe held for two cycles");

	property p_hits_monotonic;
		@(posedge clk) disable iff (!arst_n)
			state_q != ST_SWEEP |=> hit_cnt_q >= $past(hit_cnt_q);
	endproperty
	a_hits_monotonic: assert property (p_hits_monotonic)
		else $error("hit counter dropped outside an initialize");

endmodule
